### src/rtdc_pkg.sv
// Shared types, constants and the CRC table function of the run-length track decoder.
// Depends on nothing; every other file refers to it by scoped names.
package rtdc_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 16;
   localparam int CRC_W   = 32;
   localparam int TOTAL_W = 23;

   localparam logic [CRC_W-1:0]   CRC_POLY  = 32'hEDB88320;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 23'h7FFFFF;

   // Configuration register indexes.
   localparam logic CSR_EXPECTED_CRC = 1'b0;
   localparam logic CSR_TOTAL_BYTES  = 1'b1;

   // Where the decoder stands within a record.
   typedef enum logic [1:0] {
      PH_LEN_LO,
      PH_LEN_HI,
      PH_FILL,
      PH_LIT
   } phase_type;

   // Sequencer: take bytes, or repeat the CRC step for a run.
   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // Control from the sequencer to the CRC unit.
   typedef struct packed {
      logic step_en;
      logic use_fill;
   } crc_ctrl_type;

   // Entry of the 64-entry reflected table of the CRC polynomial.
   function automatic logic [CRC_W-1:0] crc_table_entry(input logic [5:0] idx);
      logic [CRC_W-1:0] e;
      e = {26'd0, idx};
      for (int j = 0; j < 8; j++) begin
         e = (e >> 1) ^ (e[0] ? CRC_POLY : {CRC_W{1'b0}});
      end
      return e;
   endfunction

endpackage

### src/rtdc_crc_unit.sv
// CRC register and its single table-driven byte step, shared by literals and run repeats.
// Depends on rtdc_pkg.
module rtdc_crc_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  rtdc_pkg::crc_ctrl_type    ctrl,
   input  logic [rtdc_pkg::BYTE_W-1:0] new_byte,
   input  logic [rtdc_pkg::BYTE_W-1:0] fill_byte,
   output logic [rtdc_pkg::CRC_W-1:0]  crc,
   output logic [rtdc_pkg::CRC_W-1:0]  crc_next
);

   logic [rtdc_pkg::CRC_W-1:0]  crc_ff;
   logic [rtdc_pkg::CRC_W-1:0]  crc_in;
   logic [rtdc_pkg::BYTE_W-1:0] data_byte;

   assign data_byte = ctrl.use_fill ? fill_byte : new_byte;

   // Only the low six bits of crc xor data address the table.
   assign crc_next = rtdc_pkg::crc_table_entry(crc_ff[5:0] ^ data_byte[5:0])
                     ^ {8'd0, crc_ff[rtdc_pkg::CRC_W-1:8]};

   assign crc_in = ctrl.step_en ? crc_next : crc_ff;
   assign crc    = crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

### src/rle_track_decoder_with_crc.sv
// Results: a literal or zero-length run result is registered in the cycle after its byte is transferred;
// a run's result is registered once the CRC unit has done all of its repeats, one repeat
// per cycle. Throughput: one byte per cycle for length and literal bytes while the result output
// does not stall; after the fill byte of a run, the input is held until its repeats are done.
// Reset: synchronous, active high; clears the record phase, totals, CRC, done flag and
// configuration (expected CRC 0, total bytes 1). Top level; depends on rtdc_pkg, rtdc_crc_unit.
module rle_track_decoder_with_crc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rtdc_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rtdc_pkg::BYTE_W-1:0]   rsp_out_value,
   output logic [rtdc_pkg::COUNT_W-1:0]  rsp_out_count,
   output logic [rtdc_pkg::CRC_W-1:0]    rsp_running_crc,
   output logic [rtdc_pkg::TOTAL_W-1:0]  rsp_decoded_total,
   output logic                          rsp_finished,
   output logic                          rsp_crc_match,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [rtdc_pkg::CRC_W-1:0]    csr_write_data
);

   rtdc_pkg::seq_state_type seq_ff, seq_in;
   rtdc_pkg::phase_type     phase_ff, phase_in;
   rtdc_pkg::crc_ctrl_type  crc_ctrl;

   logic [rtdc_pkg::BYTE_W-1:0]  len_lo_ff, len_lo_in;
   logic [rtdc_pkg::BYTE_W-1:0]  fill_ff, fill_in;
   logic [rtdc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [rtdc_pkg::COUNT_W-1:0] run_len_ff, run_len_in;
   logic [rtdc_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                         done_ff, done_in;
   logic [rtdc_pkg::CRC_W-1:0]   expected_crc_ff;
   logic [rtdc_pkg::TOTAL_W-1:0] total_bytes_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rtdc_pkg::BYTE_W-1:0]   rsp_value_ff;
   logic [rtdc_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic [rtdc_pkg::CRC_W-1:0]    rsp_crc_ff;
   logic [rtdc_pkg::TOTAL_W-1:0]  rsp_total_ff;
   logic                          rsp_fin_ff;
   logic                          rsp_match_ff;

   logic                          accept;
   logic                          work;
   logic [rtdc_pkg::COUNT_W-1:0]  len_word;
   logic [rtdc_pkg::COUNT_W-1:0]  addend;
   logic [rtdc_pkg::TOTAL_W:0]    total_sum;
   logic [rtdc_pkg::TOTAL_W-1:0]  total_sat;
   logic [rtdc_pkg::CRC_W-1:0]    crc_cur;
   logic [rtdc_pkg::CRC_W-1:0]    crc_next;

   logic                          emit_en;
   logic                          emit_end;
   logic [rtdc_pkg::BYTE_W-1:0]   emit_value;
   logic [rtdc_pkg::COUNT_W-1:0]  emit_count;
   logic [rtdc_pkg::CRC_W-1:0]    emit_crc;
   logic [rtdc_pkg::TOTAL_W-1:0]  emit_total;
   logic                          emit_fin;

   // A new byte may enter while the output register is being emptied in the same cycle.
   assign accept = req_valid & ~req_stall;
   assign work   = accept & ~done_ff;

   rtdc_crc_unit u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (crc_ctrl),
      .new_byte  (req_in_byte),
      .fill_byte (fill_ff),
      .crc       (crc_cur),
      .crc_next  (crc_next)
   );

   // Sequencer next state.
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         rtdc_pkg::SEQ_IDLE: begin
            if (work && phase_ff == rtdc_pkg::PH_FILL && count_ff != '0) begin
               seq_in = rtdc_pkg::SEQ_RUN;
            end
         end
         rtdc_pkg::SEQ_RUN: begin
            if (count_ff == 16'd1) begin
               seq_in = rtdc_pkg::SEQ_IDLE;
            end
         end
         default: seq_in = rtdc_pkg::SEQ_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall         = rsp_valid_ff & rsp_stall;
      crc_ctrl.step_en  = 1'b0;
      crc_ctrl.use_fill = 1'b0;
      case (seq_ff)
         rtdc_pkg::SEQ_IDLE: begin
            crc_ctrl.step_en = work & (phase_ff == rtdc_pkg::PH_LIT);
         end
         rtdc_pkg::SEQ_RUN: begin
            req_stall         = 1'b1;
            crc_ctrl.step_en  = 1'b1;
            crc_ctrl.use_fill = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign len_word  = {req_in_byte, len_lo_ff};
   assign addend    = (phase_ff == rtdc_pkg::PH_FILL) ? count_ff : 16'd1;
   assign total_sum = {1'b0, total_ff} + {8'd0, addend};
   assign total_sat = total_sum[rtdc_pkg::TOTAL_W] ? rtdc_pkg::TOTAL_MAX
                                                   : total_sum[rtdc_pkg::TOTAL_W-1:0];

   // Record decoding and result formation.
   always_comb begin
      phase_in   = phase_ff;
      len_lo_in  = len_lo_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      emit_en    = 1'b0;
      emit_end   = 1'b0;
      emit_value = fill_ff;
      emit_count = count_ff;
      emit_crc   = crc_next;
      emit_total = total_ff;
      if (seq_ff == rtdc_pkg::SEQ_RUN) begin
         count_in = count_ff - 16'd1;
         if (count_ff == 16'd1) begin
            emit_en    = 1'b1;
            emit_end   = 1'b1;
            emit_count = run_len_ff;
         end
      end else if (work) begin
         case (phase_ff)
            rtdc_pkg::PH_LEN_LO: begin
               len_lo_in = req_in_byte;
               phase_in  = rtdc_pkg::PH_LEN_HI;
            end
            rtdc_pkg::PH_LEN_HI: begin
               // A positive length opens literals; zero or negative opens a run of -length.
               if (len_word != '0 && !len_word[rtdc_pkg::COUNT_W-1]) begin
                  count_in = len_word;
                  phase_in = rtdc_pkg::PH_LIT;
               end else begin
                  count_in = '0 - len_word;
                  phase_in = rtdc_pkg::PH_FILL;
               end
            end
            rtdc_pkg::PH_FILL: begin
               fill_in    = req_in_byte;
               total_in   = total_sat;
               phase_in   = rtdc_pkg::PH_LEN_LO;
               if (count_ff == '0) begin
                  emit_en    = 1'b1;
                  emit_end   = 1'b1;
                  emit_value = req_in_byte;
                  emit_crc   = crc_cur;
                  emit_total = total_sat;
               end
            end
            rtdc_pkg::PH_LIT: begin
               count_in   = count_ff - 16'd1;
               total_in   = total_sat;
               emit_en    = 1'b1;
               emit_end   = (count_ff == 16'd1);
               emit_value = req_in_byte;
               emit_count = 16'd1;
               emit_total = total_sat;
               if (count_ff == 16'd1) begin
                  phase_in = rtdc_pkg::PH_LEN_LO;
               end
            end
            default: phase_in = rtdc_pkg::PH_LEN_LO;
         endcase
      end
   end

   // A run result reports its full repeat count; the counter has run down by then.
   always_comb begin
      run_len_in = run_len_ff;
      if (work && phase_ff == rtdc_pkg::PH_FILL) begin
         run_len_in = count_ff;
      end
   end

   assign emit_fin = emit_end & (emit_total >= total_bytes_ff);
   assign done_in  = done_ff | (emit_en & emit_fin);

   assign rsp_valid_in = emit_en | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff          <= rtdc_pkg::SEQ_IDLE;
         phase_ff        <= rtdc_pkg::PH_LEN_LO;
         len_lo_ff       <= '0;
         count_ff        <= '0;
         total_ff        <= '0;
         done_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         expected_crc_ff <= '0;
         total_bytes_ff  <= 23'd1;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         len_lo_ff    <= len_lo_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               rtdc_pkg::CSR_EXPECTED_CRC: expected_crc_ff <= csr_write_data;
               rtdc_pkg::CSR_TOTAL_BYTES:
                  total_bytes_ff <= csr_write_data[rtdc_pkg::TOTAL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      fill_ff    <= fill_in;
      run_len_ff <= run_len_in;
      if (emit_en) begin
         rsp_value_ff <= emit_value;
         rsp_count_ff <= emit_count;
         rsp_crc_ff   <= emit_crc;
         rsp_total_ff <= emit_total;
         rsp_fin_ff   <= emit_fin;
         rsp_match_ff <= emit_fin & (emit_crc == expected_crc_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_out_count     = rsp_count_ff;
   assign rsp_running_crc   = rsp_crc_ff;
   assign rsp_decoded_total = rsp_total_ff;
   assign rsp_finished      = rsp_fin_ff;
   assign rsp_crc_match     = rsp_match_ff;

endmodule

### src/rtdc_checker.sv
// Port-level checks on the run-length track decoder, bound to its top level.
// Depends on rtdc_pkg and rle_track_decoder_with_crc.
module rtdc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [rtdc_pkg::COUNT_W-1:0]  rsp_out_count,
   input logic [rtdc_pkg::CRC_W-1:0]    rsp_running_crc,
   input logic [rtdc_pkg::TOTAL_W-1:0]  rsp_decoded_total,
   input logic                          rsp_finished,
   input logic                          rsp_crc_match
);

   // A CRC match is only reported on a result that finishes decoding.
   a_match_needs_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_match |-> rsp_finished)
      else $error("crc_match set on a result that does not finish");

   // Once the finishing result is transferred, no further result follows.
   a_quiet_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished && !rsp_stall |=> !rsp_valid)
      else $error("result produced after decoding finished");

   // The output register is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_running_crc)
                                 && $stable(rsp_decoded_total) && $stable(rsp_out_count))
      else $error("stalled result changed");

endmodule

bind rle_track_decoder_with_crc rtdc_checker u_rtdc_checker (.*);

### sim/rle_track_decoder_with_crc_tb.sv
// Testbench for the run-length track decoder: directed records, random record streams under
// several register settings, finishing, and ignored bytes after finishing.
// Depends on rtdc_pkg and rle_track_decoder_with_crc.
`timescale 1ns / 100ps

module rle_track_decoder_with_crc_tb;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [rtdc_pkg::BYTE_W-1:0]  value;
      logic [rtdc_pkg::COUNT_W-1:0] count;
      logic [rtdc_pkg::CRC_W-1:0]   crc;
      logic [rtdc_pkg::TOTAL_W-1:0] total;
      logic                         finished;
      logic                         match;
   } decoded_item_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [rtdc_pkg::BYTE_W-1:0]   req_in_byte;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [rtdc_pkg::BYTE_W-1:0]   rsp_out_value;
   logic [rtdc_pkg::COUNT_W-1:0]  rsp_out_count;
   logic [rtdc_pkg::CRC_W-1:0]    rsp_running_crc;
   logic [rtdc_pkg::TOTAL_W-1:0]  rsp_decoded_total;
   logic                          rsp_finished;
   logic                          rsp_crc_match;
   logic                          csr_write_en;
   logic                          csr_index;
   logic [rtdc_pkg::CRC_W-1:0]    csr_write_data;

   // Decoder state as predicted from the accepted bytes.
   rtdc_pkg::phase_type           pred_phase = rtdc_pkg::PH_LEN_LO;
   logic [15:0]                   pred_length = '0;
   logic [14:0]                   pred_literals_left = '0;
   logic [rtdc_pkg::TOTAL_W-1:0]  pred_total = '0;
   logic [rtdc_pkg::CRC_W-1:0]    pred_crc = '0;
   logic                          pred_done = 1'b0;
   logic [rtdc_pkg::CRC_W-1:0]    cfg_expected_crc = '0;
   logic [rtdc_pkg::TOTAL_W-1:0]  cfg_total_bytes = 23'd1;

   decoded_item_type    pending_decodes[$];
   int                  errors = 0;
   int                  cycles = 0;
   int                  bytes_sent = 0;
   int                  big_runs_left = 3;
   int                  req_calm = 0;
   int                  rsp_calm = 0;
   int                  rsp_transfers = 0;
   int                  rsp_transfers_seen = 0;
   int                  rsp_wait = 0;

   rle_track_decoder_with_crc dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_count     (rsp_out_count),
      .rsp_running_crc   (rsp_running_crc),
      .rsp_decoded_total (rsp_decoded_total),
      .rsp_finished      (rsp_finished),
      .rsp_crc_match     (rsp_crc_match),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[rle_track_decoder_with_crc] ERROR");
         $finish;
      end
   end

   // Wait before a transfer; now and then a stretch with no waiting at all.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   // One step of the CRC with the 64-entry table, the entry worked out bit by bit.
   function automatic logic [rtdc_pkg::CRC_W-1:0] crc_next(
      input logic [rtdc_pkg::CRC_W-1:0]  c,
      input logic [rtdc_pkg::BYTE_W-1:0] b
   );
      logic [rtdc_pkg::CRC_W-1:0] t;
      t = {26'd0, c[5:0] ^ b[5:0]};
      for (int k = 0; k < 8; k++) begin
         t = t[0] ? ((t >> 1) ^ rtdc_pkg::CRC_POLY) : (t >> 1);
      end
      return t ^ (c >> 8);
   endfunction

   task automatic report_error(input string line);
      errors++;
      $display("%s", line);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
   endtask

   task automatic push_decode(input logic [rtdc_pkg::BYTE_W-1:0] value,
                              input logic [rtdc_pkg::COUNT_W-1:0] count,
                              input logic rec_end);
      decoded_item_type item;
      item.finished = rec_end && (pred_total >= cfg_total_bytes);
      if (item.finished)
         pred_done = 1'b1;
      item.value = value;
      item.count = count;
      item.crc = pred_crc;
      item.total = pred_total;
      item.match = item.finished && (pred_crc == cfg_expected_crc);
      pending_decodes.push_back(item);
   endtask

   task automatic add_to_total(input logic [16:0] n);
      logic [23:0] sum;
      sum = {1'b0, pred_total} + {7'd0, n};
      pred_total = (sum > {1'b0, rtdc_pkg::TOTAL_MAX}) ? rtdc_pkg::TOTAL_MAX
                                                        : sum[rtdc_pkg::TOTAL_W-1:0];
   endtask

   // Advances the predicted decoder by one accepted byte.
   task automatic decode_byte(input logic [rtdc_pkg::BYTE_W-1:0] b);
      logic [16:0] repeats;
      if (pred_done)
         return;
      case (pred_phase)
         rtdc_pkg::PH_LEN_LO: begin
            pred_length[7:0] = b;
            pred_phase = rtdc_pkg::PH_LEN_HI;
         end
         rtdc_pkg::PH_LEN_HI: begin
            pred_length[15:8] = b;
            if (pred_length != 16'd0 && !pred_length[15]) begin
               pred_literals_left = pred_length[14:0];
               pred_phase = rtdc_pkg::PH_LIT;
            end else begin
               pred_phase = rtdc_pkg::PH_FILL;
            end
         end
         rtdc_pkg::PH_FILL: begin
            repeats = (pred_length == 16'd0) ? 17'd0 : (17'h10000 - {1'b0, pred_length});
            for (int i = 0; i < repeats; i++)
               pred_crc = crc_next(pred_crc, b);
            add_to_total(repeats);
            pred_phase = rtdc_pkg::PH_LEN_LO;
            push_decode(b, repeats[15:0], 1'b1);
         end
         rtdc_pkg::PH_LIT: begin
            pred_crc = crc_next(pred_crc, b);
            add_to_total(17'd1);
            pred_literals_left = pred_literals_left - 15'd1;
            if (pred_literals_left == 15'd0)
               pred_phase = rtdc_pkg::PH_LEN_LO;
            push_decode(b, 16'd1, pred_literals_left == 15'd0);
         end
         default: pred_phase = rtdc_pkg::PH_LEN_LO;
      endcase
   endtask

   // Result side: check every transfer against the oldest pending decode.
   always @(posedge clock) begin : rsp_check
      decoded_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_transfers++;
         if (pending_decodes.size() == 0) begin
            report_error($sformatf("unexpected result: value %0h count %0d",
                                   rsp_out_value, rsp_out_count));
         end else begin
            want = pending_decodes.pop_front();
            check_field("out_value", 32'(rsp_out_value), 32'(want.value));
            check_field("out_count", 32'(rsp_out_count), 32'(want.count));
            check_field("running_crc", rsp_running_crc, want.crc);
            check_field("decoded_total", 32'(rsp_decoded_total), 32'(want.total));
            check_field("finished", 32'(rsp_finished), 32'(want.finished));
            check_field("crc_match", 32'(rsp_crc_match), 32'(want.match));
         end
      end
   end

   // A fresh stall length is drawn after every result transfer.
   always @(negedge clock) begin
      if (rsp_transfers != rsp_transfers_seen) begin
         rsp_transfers_seen = rsp_transfers;
         rsp_wait = draw_wait(rsp_calm);
      end
      rsp_stall <= (rsp_wait > 0);
      if (rsp_wait > 0)
         rsp_wait--;
   end

   task automatic send_byte(input logic [rtdc_pkg::BYTE_W-1:0] b);
      int gap;
      gap = draw_wait(req_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      if (!pred_done)
         bytes_sent++;
      decode_byte(b);
   endtask

   task automatic send_length(input logic [15:0] len);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
   endtask

   // Stop sending and let every pending result and any run in progress come out.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_decodes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [rtdc_pkg::CRC_W-1:0] crc_val,
                             input logic [rtdc_pkg::TOTAL_W-1:0] total_val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= rtdc_pkg::CSR_EXPECTED_CRC;
      csr_write_data <= crc_val;
      @(negedge clock);
      csr_index <= rtdc_pkg::CSR_TOTAL_BYTES;
      csr_write_data <= {9'd0, total_val};
      @(negedge clock);
      csr_write_en <= 1'b0;
      cfg_expected_crc = crc_val;
      cfg_total_bytes = total_val;
   endtask

   task automatic send_random_record();
      int pick;
      int n;
      logic [15:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if (pick < 2)
            n = $urandom_range(100, 300);
         else if (pick < 8)
            n = $urandom_range(9, 64);
         else
            n = $urandom_range(1, 8);
         len = 16'(n);
         send_length(len);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else begin
         if (pick < 55)
            len = 16'd0;
         else if (pick < 83)
            len = 16'h0 - 16'($urandom_range(1, 16));
         else if (pick < 90)
            len = 16'h0 - 16'($urandom_range(17, 512));
         else if (pick < 95 && big_runs_left > 0) begin
            big_runs_left--;
            len = {1'b1, 15'($urandom)};
         end else
            len = {7'h7F, 1'b1, 8'($urandom)};
         send_length(len);
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Extreme bytes, zero-length, single and longest runs, and short literal records.
   task automatic test_directed_records();
      write_regs(32'hFFFF_FFFF, rtdc_pkg::TOTAL_MAX);
      send_length(16'd1);
      send_byte(8'h00);
      send_length(16'd3);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_length(16'h0000);
      send_byte(8'hFF);
      send_length(16'hFFFF);
      send_byte(8'h00);
      send_length(16'h8000);
      send_byte(8'h81);
      send_length(16'h8001);
      send_byte(8'h7E);
      send_length(16'd2);
      send_byte(8'h3C);
      send_byte(8'hC3);
   endtask

   task automatic test_random_records(input int n_bytes,
                                      input logic [rtdc_pkg::CRC_W-1:0] crc_val,
                                      input logic [rtdc_pkg::TOTAL_W-1:0] total_val);
      int stop_at;
      drain();
      write_regs(crc_val, total_val);
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at)
         send_random_record();
   endtask

   // Finishing, either on a zero-length run with a matching CRC or partway through records.
   task automatic test_finish();
      int mode;
      drain();
      mode = $urandom_range(0, 2);
      if (mode == 2) begin
         write_regs(32'($urandom), pred_total + 23'($urandom_range(1, 200)));
         while (!pred_done)
            send_random_record();
      end else begin
         write_regs(pred_crc, (mode == 0) ? 23'd0 : pred_total);
         send_length(16'h0000);
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_after_finish();
      repeat (16) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = '0;
      csr_write_en = 1'b0;
      csr_index = rtdc_pkg::CSR_EXPECTED_CRC;
      csr_write_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_records();
      test_random_records(210, 32'($urandom), 23'h400000);
      test_random_records(210, 32'h0, rtdc_pkg::TOTAL_MAX);
      test_random_records(210, 32'($urandom), 23'h400000 | 23'($urandom_range(0, 23'h3FFFFF)));
      test_random_records(210, 32'hFFFF_FFFF, 23'h400000);
      test_finish();
      test_after_finish();

      drain();
      repeat (20) @(posedge clock);
      if (pending_decodes.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_decodes.size()));
      if (errors == 0)
         $display("[rle_track_decoder_with_crc] OK");
      else
         $display("[rle_track_decoder_with_crc] ERROR");
      $finish;
   end

endmodule
